[rtl/dhlt_pkg.sv]
`timescale 1ns / 1ps

package dhlt_pkg;

    localparam int ATAN_ENTRIES = 24;

    // Q2.30 datapath with headroom, residual angle in 2^-32 turn
    localparam int XY_W = 34;
    localparam int Z_W  = 34;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam logic signed [16:0] QUARTER_TURN = 17'sd16384;
    localparam logic signed [16:0] HALF_TURN    = 17'sd32768;

    localparam logic signed [15:0] ROT_ONE  = 16'sd16384;
    localparam logic signed [15:0] ROT_MONE = -16'sd16384;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } lane_t;

    typedef struct packed {
        logic [3:0]         tag;
        logic signed [31:0] len;
        logic signed [31:0] off;
        lane_t              th;
        lane_t              al;
    } cordic_beat_t;

    // Fold into +-quarter turn and load the rotator start vector
    function automatic lane_t lane_init(input logic signed [15:0] b);
        lane_t              l;
        logic signed [16:0] bw;
        logic signed [16:0] br;
        bw     = {b[15], b};
        br     = bw;
        l.flip = 1'b0;
        if (bw > QUARTER_TURN)
        begin
            br     = bw - HALF_TURN;
            l.flip = 1'b1;
        end
        else if (bw < -QUARTER_TURN)
        begin
            br     = bw + HALF_TURN;
            l.flip = 1'b1;
        end
        l.x = CORDIC_GAIN;
        l.y = '0;
        l.z = {{(Z_W-33){br[16]}}, br, 16'h0000};
        return l;
    endfunction

endpackage

[rtl/dhlt_pre.sv]
`timescale 1ns / 1ps

module dhlt_pre
    import dhlt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         joint_index,
    input  logic signed [15:0] joint_angle,
    input  logic signed [15:0] angle_offset,
    input  logic signed [15:0] twist_angle,
    input  logic signed [31:0] link_length,
    input  logic signed [31:0] link_offset,
    output logic               out_valid,
    input  logic               out_ready,
    output cordic_beat_t       out_beat
);

    logic               valid_reg;
    cordic_beat_t       beat_reg;
    cordic_beat_t       beat_next;
    logic signed [15:0] th_sum;

    // binary angle sum wraps at one turn
    assign th_sum = joint_angle + angle_offset;

    always_comb
    begin
        beat_next.tag = joint_index;
        beat_next.len = link_length;
        beat_next.off = link_offset;
        beat_next.th  = lane_init(th_sum);
        beat_next.al  = lane_init(twist_angle);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

[rtl/dhlt_cordic_stage.sv]
`timescale 1ns / 1ps

module dhlt_cordic_stage
    import dhlt_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  cordic_beat_t in_beat,
    output logic         out_valid,
    input  logic         out_ready,
    output cordic_beat_t out_beat
);

    logic         valid_reg;
    cordic_beat_t beat_reg;
    cordic_beat_t beat_next;

    // one micro-rotation; non-negative residual rotates forward
    function automatic lane_t rotate(input lane_t l);
        lane_t                  r;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [Z_W-1:0]  at;
        xs     = $signed(l.x) >>> SHIFT;
        ys     = $signed(l.y) >>> SHIFT;
        at     = $signed({{(Z_W-32){1'b0}}, ATAN_TURNS[SHIFT]});
        r.flip = l.flip;
        if (!l.z[Z_W-1])
        begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - at;
        end
        else
        begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + at;
        end
        return r;
    endfunction

    always_comb
    begin
        beat_next    = in_beat;
        beat_next.th = rotate(in_beat.th);
        beat_next.al = rotate(in_beat.al);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

[rtl/dhlt_post.sv]
`timescale 1ns / 1ps

module dhlt_post
    import dhlt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cordic_beat_t       in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         tag_out,
    output logic signed [15:0] rot_11,
    output logic signed [15:0] rot_12,
    output logic signed [15:0] rot_21,
    output logic signed [15:0] rot_22,
    output logic signed [15:0] rot_23,
    output logic signed [15:0] rot_31,
    output logic signed [15:0] rot_32,
    output logic signed [15:0] rot_33,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z
);

    typedef struct packed {
        logic [3:0]         tag;
        logic signed [31:0] len;
        logic signed [31:0] off;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic signed [15:0] ns;
        logic signed [15:0] ca;
        logic signed [15:0] sa;
        logic signed [15:0] nsa;
    } trig_t;

    typedef struct packed {
        logic [3:0]         tag;
        logic signed [31:0] len;
        logic signed [15:0] c;
        logic signed [15:0] ns;
        logic signed [15:0] ca;
        logic signed [15:0] nsa;
        logic signed [29:0] p_sca;
        logic signed [29:0] p_cca;
        logic signed [29:0] p_ssa;
        logic signed [29:0] p_csa;
        logic signed [47:0] p_y;
        logic signed [47:0] p_z;
    } prod_t;

    typedef struct packed {
        logic [3:0]         tag;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [15:0] r23;
        logic signed [15:0] r31;
        logic signed [15:0] r32;
        logic signed [15:0] r33;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } res_t;

    localparam logic signed [XY_W-1:0] RND_Q30 = 34'sd32768;
    localparam logic signed [29:0]     RND_ROT = 30'sd8192;
    localparam logic signed [47:0]     RND_POS = 48'sd8192;
    localparam logic signed [47:0]     POS_MAX = 48'sd2147483647;
    localparam logic signed [47:0]     POS_MIN = -48'sd2147483648;

    function automatic logic signed [15:0] to_q14(input logic signed [XY_W-1:0] v,
                                                   input logic flip);
        logic signed [XY_W-1:0] r;
        logic signed [15:0]     q;
        r = (v + RND_Q30) >>> 16;
        if (r > ROT_ONE)
        begin
            q = ROT_ONE;
        end
        else if (r < ROT_MONE)
        begin
            q = ROT_MONE;
        end
        else
        begin
            q = r[15:0];
        end
        if (flip)
        begin
            q = -q;
        end
        return q;
    endfunction

    function automatic logic signed [15:0] round_rot(input logic signed [29:0] p);
        logic signed [29:0] r;
        logic signed [15:0] q;
        r = (p + RND_ROT) >>> 14;
        if (r > ROT_ONE)
        begin
            q = ROT_ONE;
        end
        else if (r < ROT_MONE)
        begin
            q = ROT_MONE;
        end
        else
        begin
            q = r[15:0];
        end
        return q;
    endfunction

    function automatic logic signed [31:0] round_pos(input logic signed [47:0] p);
        logic signed [47:0] r;
        logic signed [31:0] q;
        r = (p + RND_POS) >>> 14;
        if (r > POS_MAX)
        begin
            q = POS_MAX[31:0];
        end
        else if (r < POS_MIN)
        begin
            q = POS_MIN[31:0];
        end
        else
        begin
            q = r[31:0];
        end
        return q;
    endfunction

    logic  a_valid_reg;
    logic  b_valid_reg;
    logic  c_valid_reg;
    logic  a_ready;
    logic  b_ready;
    logic  c_ready;
    trig_t a_reg;
    trig_t a_next;
    prod_t b_reg;
    prod_t b_next;
    res_t  c_reg;
    res_t  c_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage A: round, clamp and unfold the rotator outputs
    always_comb
    begin
        a_next.tag = in_beat.tag;
        a_next.len = in_beat.len;
        a_next.off = in_beat.off;
        a_next.c   = to_q14(in_beat.th.x, in_beat.th.flip);
        a_next.s   = to_q14(in_beat.th.y, in_beat.th.flip);
        a_next.ca  = to_q14(in_beat.al.x, in_beat.al.flip);
        a_next.sa  = to_q14(in_beat.al.y, in_beat.al.flip);
        a_next.ns  = -a_next.s;
        a_next.nsa = -a_next.sa;
    end

    // stage B: products
    always_comb
    begin
        b_next.tag   = a_reg.tag;
        b_next.len   = a_reg.len;
        b_next.c     = a_reg.c;
        b_next.ns    = a_reg.ns;
        b_next.ca    = a_reg.ca;
        b_next.nsa   = a_reg.nsa;
        b_next.p_sca = 30'(a_reg.s) * 30'(a_reg.ca);
        b_next.p_cca = 30'(a_reg.c) * 30'(a_reg.ca);
        b_next.p_ssa = 30'(a_reg.s) * 30'(a_reg.sa);
        b_next.p_csa = 30'(a_reg.c) * 30'(a_reg.sa);
        b_next.p_y   = 48'(a_reg.off) * 48'(a_reg.nsa);
        b_next.p_z   = 48'(a_reg.off) * 48'(a_reg.ca);
    end

    // stage C: round and saturate into the output register
    always_comb
    begin
        c_next.tag = b_reg.tag;
        c_next.r11 = b_reg.c;
        c_next.r12 = b_reg.ns;
        c_next.r21 = round_rot(b_reg.p_sca);
        c_next.r22 = round_rot(b_reg.p_cca);
        c_next.r23 = b_reg.nsa;
        c_next.r31 = round_rot(b_reg.p_ssa);
        c_next.r32 = round_rot(b_reg.p_csa);
        c_next.r33 = b_reg.ca;
        c_next.px  = b_reg.len;
        c_next.py  = round_pos(b_reg.p_y);
        c_next.pz  = round_pos(b_reg.p_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
        if (c_ready && b_valid_reg)
        begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign tag_out   = c_reg.tag;
    assign rot_11    = c_reg.r11;
    assign rot_12    = c_reg.r12;
    assign rot_21    = c_reg.r21;
    assign rot_22    = c_reg.r22;
    assign rot_23    = c_reg.r23;
    assign rot_31    = c_reg.r31;
    assign rot_32    = c_reg.r32;
    assign rot_33    = c_reg.r33;
    assign pos_x     = c_reg.px;
    assign pos_y     = c_reg.py;
    assign pos_z     = c_reg.pz;

endmodule

[rtl/dh_link_transform_top.sv]
`timescale 1ns / 1ps
// Modified DH link transform, one link per beat.
// Pipeline: one prep stage, one stage per CORDIC step, round, multiply and
// round/saturate stages. Throughput: one beat per cycle while out_ready holds;
// each stage stalls only while it holds a beat.
// Reset: rst_n asynchronous, active low, clears the stage valid bits only.
module dh_link_transform_top
    import dhlt_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         joint_index,
    input  logic signed [15:0] joint_angle,
    input  logic signed [15:0] angle_offset,
    input  logic signed [15:0] twist_angle,
    input  logic signed [31:0] link_length,
    input  logic signed [31:0] link_offset,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         tag_out,
    output logic signed [15:0] rot_11,
    output logic signed [15:0] rot_12,
    output logic signed [15:0] rot_21,
    output logic signed [15:0] rot_22,
    output logic signed [15:0] rot_23,
    output logic signed [15:0] rot_31,
    output logic signed [15:0] rot_32,
    output logic signed [15:0] rot_33,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z
);

    localparam int NUM_STAGES = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    cordic_beat_t beat_w  [NUM_STAGES+1];
    logic         valid_w [NUM_STAGES+1];
    logic         ready_w [NUM_STAGES+1];

    dhlt_pre u_pre (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .joint_index  (joint_index),
        .joint_angle  (joint_angle),
        .angle_offset (angle_offset),
        .twist_angle  (twist_angle),
        .link_length  (link_length),
        .link_offset  (link_offset),
        .out_valid    (valid_w[0]),
        .out_ready    (ready_w[0]),
        .out_beat     (beat_w[0])
    );

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : gen_cordic
        dhlt_cordic_stage #(
            .SHIFT (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[k]),
            .in_ready  (ready_w[k]),
            .in_beat   (beat_w[k]),
            .out_valid (valid_w[k+1]),
            .out_ready (ready_w[k+1]),
            .out_beat  (beat_w[k+1])
        );
    end

    dhlt_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_w[NUM_STAGES]),
        .in_ready  (ready_w[NUM_STAGES]),
        .in_beat   (beat_w[NUM_STAGES]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tag_out   (tag_out),
        .rot_11    (rot_11),
        .rot_12    (rot_12),
        .rot_21    (rot_21),
        .rot_22    (rot_22),
        .rot_23    (rot_23),
        .rot_31    (rot_31),
        .rot_32    (rot_32),
        .rot_33    (rot_33),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z)
    );

endmodule

[rtl/dhlt_checker.sv]
`timescale 1ns / 1ps

module dhlt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] rot_11,
    input logic signed [15:0] rot_12,
    input logic signed [15:0] rot_21,
    input logic signed [15:0] rot_22,
    input logic signed [15:0] rot_33,
    input logic signed [31:0] pos_y,
    input logic signed [31:0] pos_z
);

    // a stalled result beat stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_y) && $stable(rot_21))
        else $error("stalled result beat changed");

    // input back-pressure only when the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with output free");

    // zero twist: second row equals the first row rotated
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rot_33 == 16'sd16384 |-> rot_21 == -rot_12 && rot_22 == rot_11)
        else $error("unit cos(alpha) row mismatch");

    // quarter twist: cos(alpha) zero kills the dependent products
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rot_33 == 16'sd0 |-> rot_21 == 16'sd0 && rot_22 == 16'sd0 && pos_z == 32'sd0)
        else $error("zero cos(alpha) products not zero");

endmodule

bind dh_link_transform_top dhlt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rot_11    (rot_11),
    .rot_12    (rot_12),
    .rot_21    (rot_21),
    .rot_22    (rot_22),
    .rot_33    (rot_33),
    .pos_y     (pos_y),
    .pos_z     (pos_z)
);
